// ===== sv/mdps_pkg.sv =====
package mdps_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_APPEND_A = 2'd1,
        CMD_APPEND_B = 2'd2,
        CMD_COMPUTE  = 2'd3
    } t_cmd;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    typedef struct packed {
        t_cmd               command;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_in_item;

    typedef struct packed {
        logic [32:0] min_sq_distance;
        logic [16:0] min_distance;
        logic [7:0]  index_a;
        logic [7:0]  index_b;
        logic [1:0]  status;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd_en;
        logic scan_start;
        logic sqrt_start;
        logic load_out;
        logic out_empty;
        logic out_dropped;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic sqrt_busy;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== sv/min_distance_between_point_sets_top.sv =====
// Append and clear items are accepted back to back while idle.
// Compute: the pair scan issues one pair per cycle over a 4-stage
// read/subtract/square/compare pipe, then a bit-serial square root runs.
// A compute on an empty set skips the scan and the root.
// Reset (synchronous, active low) empties both sets and clears the drop flag.
module min_distance_between_point_sets_top #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mdps_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mdps_pkg::t_out_item o_out_data
);
    import mdps_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    // command and status between sequencer and datapath
    t_dp_cmd       dp_cmd;
    t_dp_stat      dp_stat;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;

    // Sequencer: owns set counts, drop flag and the A-outer/B-inner scan
    // counters; holds off new items until a compute has its result loaded.
    mdps_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_cmd    (i_in_data.command),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b)
    );

    // Datapath: point memories, distance pipe, running minimum, bit-serial
    // square root and the output register that parts the result side.
    mdps_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .i_wr_addr   (wr_addr),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/mdps_ctrl.sv =====
module mdps_ctrl #(
    parameter int MAX_POINTS = 256,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mdps_pkg::t_cmd     i_in_cmd,
    input  mdps_pkg::t_dp_stat i_stat,
    output mdps_pkg::t_dp_cmd  o_cmd,
    output logic [AW-1:0]      o_wr_addr,
    output logic [AW-1:0]      o_rd_addr_a,
    output logic [AW-1:0]      o_rd_addr_b
);
    import mdps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SQRT,
        ST_EMIT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt_a;
    logic [CW-1:0]   r_cnt_b;
    logic            r_dropped;
    logic            r_empty;
    logic [AW-1:0]   r_i;
    logic [AW-1:0]   r_j;

    logic            accept;
    logic            full_a;
    logic            full_b;
    logic            empty_any;
    logic            last_j;
    logic            last_i;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign full_a      = (r_cnt_a == CW'(MAX_POINTS));
    assign full_b      = (r_cnt_b == CW'(MAX_POINTS));
    assign empty_any   = (r_cnt_a == '0) || (r_cnt_b == '0);
    assign last_j      = ((CW'(r_j) + CW'(1)) == r_cnt_b);
    assign last_i      = ((CW'(r_i) + CW'(1)) == r_cnt_a);
    assign o_rd_addr_a = r_i;
    assign o_rd_addr_b = r_j;

    always_comb begin
        o_cmd     = '0;
        o_wr_addr = (i_in_cmd == CMD_APPEND_A) ? r_cnt_a[AW-1:0] : r_cnt_b[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_cmd)
                        CMD_APPEND_A: o_cmd.wr_a       = !full_a;
                        CMD_APPEND_B: o_cmd.wr_b       = !full_b;
                        CMD_COMPUTE:  o_cmd.scan_start = !empty_any;
                        default:      o_cmd.wr_a       = 1'b0;
                    endcase
                end
            end
            ST_SCAN:  o_cmd.rd_en      = 1'b1;
            ST_DRAIN: o_cmd.sqrt_start = !i_stat.pipe_busy;
            ST_EMIT: begin
                o_cmd.load_out    = i_stat.out_free;
                o_cmd.out_empty   = r_empty;
                o_cmd.out_dropped = r_dropped;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_dropped <= 1'b0;
            r_empty   <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_in_cmd)
                            CMD_CLEAR: begin
                                r_cnt_a   <= '0;
                                r_cnt_b   <= '0;
                                r_dropped <= 1'b0;
                            end
                            CMD_APPEND_A: begin
                                if (full_a) r_dropped <= 1'b1;
                                else        r_cnt_a   <= r_cnt_a + CW'(1);
                            end
                            CMD_APPEND_B: begin
                                if (full_b) r_dropped <= 1'b1;
                                else        r_cnt_b   <= r_cnt_b + CW'(1);
                            end
                            CMD_COMPUTE: begin
                                r_empty <= empty_any;
                                r_i     <= '0;
                                r_j     <= '0;
                                r_state <= empty_any ? ST_EMIT : ST_SCAN;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SCAN: begin
                    // B is the inner loop
                    if (last_j) begin
                        r_j <= '0;
                        if (last_i) r_state <= ST_DRAIN;
                        else        r_i     <= r_i + AW'(1);
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!i_stat.pipe_busy) r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (!i_stat.sqrt_busy) r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (i_stat.out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt_a != '0 && r_cnt_b != '0))
        else $error("scan running over an empty set");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CW'(r_i) < r_cnt_a && CW'(r_j) < r_cnt_b))
        else $error("scan index past fill count");

    a_counts_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> $stable(r_cnt_a) && $stable(r_cnt_b))
        else $error("set count changed during compute");

endmodule

// ===== sv/mdps_dp.sv =====
module mdps_dp #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int CB = COORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mdps_pkg::t_in_item  i_in_data,
    input  mdps_pkg::t_dp_cmd   i_cmd,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [AW-1:0]       i_rd_addr_a,
    input  logic [AW-1:0]       i_rd_addr_b,
    output mdps_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mdps_pkg::t_out_item o_out_data
);
    import mdps_pkg::*;

    localparam int DW  = 2 * CB + 1;   // squared distance
    localparam int R   = CB + 1;       // root bits
    localparam int VW  = 2 * R;        // radicand, padded to even width
    localparam int RW  = R + 3;        // partial remainder
    localparam int SCW = $clog2(R);

    // point stores, x in the upper half
    logic [2*CB-1:0] mem_a [MAX_POINTS];
    logic [2*CB-1:0] mem_b [MAX_POINTS];

    logic [CB+15:0]  x_ext;
    logic [CB+15:0]  y_ext;
    logic [2*CB-1:0] wr_point;

    logic            r_v1, r_v2, r_v3;
    logic [2*CB-1:0] r_pa, r_pb;
    logic [AW-1:0]   r_i1, r_j1, r_i2, r_j2, r_i3, r_j3;
    logic [CB-1:0]   r_adx, r_ady;
    logic [2*CB-1:0] r_sx, r_sy;

    logic signed [CB:0] dx, dy;
    logic [CB:0]        adx_w, ady_w;
    logic [DW-1:0]      pair_dist;

    logic            r_have;
    logic [DW-1:0]   r_best;
    logic [AW-1:0]   r_best_i, r_best_j;

    logic            r_sq_busy;
    logic [SCW-1:0]  r_sq_cnt;
    logic [VW-1:0]   r_val;
    logic [RW-1:0]   r_rem;
    logic [R-1:0]    r_root;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic [RW-1:0]   rem_nx;
    logic [R-1:0]    root_nx;

    logic            r_out_valid;
    t_out_item       r_out;
    logic [DW+32:0]  sq_ext;
    logic [R+16:0]   rt_ext;
    logic [AW+7:0]   ia_ext, ib_ext;

    // field bits are taken as unsigned, then reinterpreted at COORD_BITS
    assign x_ext    = (CB+16)'($unsigned(i_in_data.x));
    assign y_ext    = (CB+16)'($unsigned(i_in_data.y));
    assign wr_point = {x_ext[CB-1:0], y_ext[CB-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) mem_a[i_wr_addr] <= wr_point;
        r_pa <= mem_a[i_rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) mem_b[i_wr_addr] <= wr_point;
        r_pb <= mem_b[i_rd_addr_b];
    end

    assign dx    = (CB+1)'($signed(r_pa[2*CB-1:CB])) - (CB+1)'($signed(r_pb[2*CB-1:CB]));
    assign dy    = (CB+1)'($signed(r_pa[CB-1:0])) - (CB+1)'($signed(r_pb[CB-1:0]));
    assign adx_w = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
    assign ady_w = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
    assign pair_dist = DW'(r_sx) + DW'(r_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1  <= i_rd_addr_a;
        r_j1  <= i_rd_addr_b;
        r_i2  <= r_i1;
        r_j2  <= r_j1;
        r_adx <= adx_w[CB-1:0];
        r_ady <= ady_w[CB-1:0];
        r_i3  <= r_i2;
        r_j3  <= r_j2;
        r_sx  <= r_adx * r_adx;
        r_sy  <= r_ady * r_ady;
    end

    // running minimum, first pair seeds it, strict compare keeps ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_have <= 1'b0;
        end else if (r_v3) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && (!r_have || pair_dist < r_best)) begin
            r_best   <= pair_dist;
            r_best_i <= r_i3;
            r_best_j <= r_j3;
        end
    end

    // integer square root, one result bit per cycle
    assign rem_sh = {r_rem[RW-3:0], r_val[VW-1:VW-2]};
    assign trial  = {(RW-2)'(r_root), 2'b01};

    always_comb begin
        if (rem_sh >= trial) begin
            rem_nx  = rem_sh - trial;
            root_nx = {r_root[R-2:0], 1'b1};
        end else begin
            rem_nx  = rem_sh;
            root_nx = {r_root[R-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_cnt  <= '0;
        end else if (i_cmd.sqrt_start) begin
            r_sq_busy <= 1'b1;
            r_sq_cnt  <= '0;
        end else if (r_sq_busy) begin
            r_sq_cnt <= r_sq_cnt + SCW'(1);
            if (r_sq_cnt == SCW'(R - 1)) r_sq_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_val  <= VW'(r_best);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_sq_busy) begin
            r_val  <= {r_val[VW-3:0], 2'b00};
            r_rem  <= rem_nx;
            r_root <= root_nx;
        end
    end

    assign sq_ext = (DW+33)'(r_best);
    assign rt_ext = (R+17)'(r_root);
    assign ia_ext = (AW+8)'(r_best_i);
    assign ib_ext = (AW+8)'(r_best_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.out_empty) begin
                r_out.min_sq_distance <= '0;
                r_out.min_distance    <= '0;
                r_out.index_a         <= '0;
                r_out.index_b         <= '0;
                r_out.status          <= STATUS_EMPTY;
            end else begin
                r_out.min_sq_distance <= sq_ext[32:0];
                r_out.min_distance    <= rt_ext[16:0];
                r_out.index_a         <= ia_ext[7:0];
                r_out.index_b         <= ib_ext[7:0];
                r_out.status          <= i_cmd.out_dropped ? STATUS_DROPPED : STATUS_OK;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;
    assign o_stat.pipe_busy = r_v1 || r_v2 || r_v3;
    assign o_stat.sqrt_busy = r_sq_busy;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |=> r_v2 ##1 r_v3)
        else $error("pair lost in distance pipeline");

    a_sqrt_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_start |-> !(r_v1 || r_v2 || r_v3) && !r_sq_busy)
        else $error("root started before minimum settled");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before taken");

endmodule
